// ----- rtl/core/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg: shared definitions for the linear probing map
// Request and status codes, field widths, the per-slot metadata word and
// the result of one slot evaluation.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Default sizing of the table.
  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KEY_BITS_DEF = 64;

  // Fixed field widths of the request and result ports.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Chain counters saturate at both ends.
  localparam int unsigned          COUNT_W   = 9;
  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ERASE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Metadata held for every slot.
  typedef struct packed {
    logic               busy;
    logic [COUNT_W-1:0] count;
  } meta_t;

  // Outcome of comparing one slot against the current request.
  typedef struct packed {
    logic               same_hash;
    logic               hit;
    logic               count_zero;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_dec;
  } eval_t;

  // Write enables towards the slot store.
  typedef struct packed {
    logic meta_we;
    logic data_we;
  } store_cmd_t;

endpackage

// ----- rtl/core/lpm_slot_eval.sv -----
// ----------------------------------------------------------------------------
// lpm_slot_eval: slot compare and count update unit
// Compares one slot read from the store with the current request and
// forms the saturated chain count increments and decrements.
// ----------------------------------------------------------------------------
module lpm_slot_eval #(
  parameter int unsigned KEY_BITS = lpm_pkg::KEY_BITS_DEF
) (
  input  lpm_pkg::meta_t                  meta_i,
  input  logic [KEY_BITS-1:0]             key_i,
  input  logic [lpm_pkg::HASH_W-1:0]      hash_i,
  input  logic [KEY_BITS-1:0]             req_key_i,
  input  logic [lpm_pkg::HASH_W-1:0]      req_hash_i,
  output lpm_pkg::eval_t                  eval_o
);

  // A busy slot with the same hash is part of this key's chain.
  always_comb begin
    eval_o.same_hash  = meta_i.busy && (hash_i == req_hash_i);
    eval_o.hit        = eval_o.same_hash && (key_i == req_key_i);
    eval_o.count_zero = (meta_i.count == '0);
    // Saturating count updates.
    if (meta_i.count == lpm_pkg::COUNT_MAX) begin
      eval_o.count_inc = meta_i.count;
    end else begin
      eval_o.count_inc = meta_i.count + lpm_pkg::COUNT_W'(1);
    end
    if (eval_o.count_zero) begin
      eval_o.count_dec = meta_i.count;
    end else begin
      eval_o.count_dec = meta_i.count - lpm_pkg::COUNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/lpm_slot_store.sv -----
// ----------------------------------------------------------------------------
// lpm_slot_store: slot memories of the linear probing map
// Metadata and key/hash/value memories, one write port and one registered
// read port each, sharing the same addresses.
// ----------------------------------------------------------------------------
module lpm_slot_store #(
  parameter int unsigned CAPACITY = lpm_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = lpm_pkg::KEY_BITS_DEF,
  localparam int unsigned AW      = $clog2(CAPACITY)
) (
  input  logic                          clk_i,
  input  logic [AW-1:0]                 rd_addr_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  lpm_pkg::store_cmd_t           cmd_i,
  input  lpm_pkg::meta_t                meta_wr_i,
  input  logic [KEY_BITS-1:0]           key_wr_i,
  input  logic [lpm_pkg::HASH_W-1:0]    hash_wr_i,
  input  logic [lpm_pkg::VALUE_W-1:0]   value_wr_i,
  output lpm_pkg::meta_t                meta_rd_o,
  output logic [KEY_BITS-1:0]           key_rd_o,
  output logic [lpm_pkg::HASH_W-1:0]    hash_rd_o,
  output logic [lpm_pkg::VALUE_W-1:0]   value_rd_o
);

  lpm_pkg::meta_t                meta_mem_q  [CAPACITY];
  logic [KEY_BITS-1:0]           key_mem_q   [CAPACITY];
  logic [lpm_pkg::HASH_W-1:0]    hash_mem_q  [CAPACITY];
  logic [lpm_pkg::VALUE_W-1:0]   value_mem_q [CAPACITY];

  // Metadata memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.meta_we) begin
      meta_mem_q[wr_addr_i] <= meta_wr_i;
    end
    meta_rd_o <= meta_mem_q[rd_addr_i];
  end

  // Key, hash and value memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_we) begin
      key_mem_q[wr_addr_i]   <= key_wr_i;
      hash_mem_q[wr_addr_i]  <= hash_wr_i;
      value_mem_q[wr_addr_i] <= value_wr_i;
    end
    key_rd_o   <= key_mem_q[rd_addr_i];
    hash_rd_o  <= hash_mem_q[rd_addr_i];
    value_rd_o <= value_mem_q[rd_addr_i];
  end

endmodule

// ----- rtl/core/lpm_probe_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpm_probe_ctrl: probe sequencer of the linear probing map
// Clears the metadata after reset, then walks the probe path of each
// request one slot per cycle through the shared slot evaluation unit.
// ----------------------------------------------------------------------------
module lpm_probe_ctrl #(
  parameter int unsigned CAPACITY = lpm_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = lpm_pkg::KEY_BITS_DEF,
  localparam int unsigned AW      = $clog2(CAPACITY)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request side.
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lpm_pkg::REQ_W-1:0]            req_type_i,
  input  logic [lpm_pkg::KEY_W-1:0]            key_i,
  input  logic [lpm_pkg::HASH_W-1:0]           key_hash_i,
  input  logic signed [lpm_pkg::VALUE_W-1:0]   value_in_i,
  // Slot store.
  output logic [AW-1:0]                        rd_addr_o,
  output logic [AW-1:0]                        wr_addr_o,
  output lpm_pkg::store_cmd_t                  cmd_o,
  output lpm_pkg::meta_t                       meta_wr_o,
  output logic [KEY_BITS-1:0]                  key_wr_o,
  output logic [lpm_pkg::HASH_W-1:0]           hash_wr_o,
  output logic [lpm_pkg::VALUE_W-1:0]          value_wr_o,
  input  lpm_pkg::meta_t                       meta_rd_i,
  input  logic [KEY_BITS-1:0]                  key_rd_i,
  input  logic [lpm_pkg::HASH_W-1:0]           hash_rd_i,
  input  logic [lpm_pkg::VALUE_W-1:0]          value_rd_i,
  // Result side.
  output logic                                 done_o,
  output logic [lpm_pkg::STATUS_W-1:0]         status_o,
  output logic signed [lpm_pkg::VALUE_W-1:0]   value_out_o,
  output logic [lpm_pkg::KEY_W-1:0]            removed_key_o
);

  localparam int unsigned   OW       = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST     = AW'(CAPACITY - 1);
  localparam logic [OW-1:0] OCC_FULL = OW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_e;

  state_e                          state_q, state_d;
  logic [AW-1:0]                   idx_q, idx_d;
  logic [AW-1:0]                   step_q, step_d;
  logic [OW-1:0]                   occ_q, occ_d;
  logic [lpm_pkg::REQ_W-1:0]       req_q, req_d;
  logic [KEY_BITS-1:0]             key_q, key_d;
  logic [lpm_pkg::HASH_W-1:0]      hash_q, hash_d;
  logic [lpm_pkg::VALUE_W-1:0]     val_in_q, val_in_d;
  logic                            done_q, done_d;
  logic [lpm_pkg::STATUS_W-1:0]    status_q, status_d;
  logic [lpm_pkg::VALUE_W-1:0]     vout_q, vout_d;
  logic [lpm_pkg::KEY_W-1:0]       rkey_q, rkey_d;
  logic                            last_slot;
  lpm_pkg::eval_t                  eval;

  // Shared compare and count update unit for the slot on the read port.
  lpm_slot_eval #(
    .KEY_BITS (KEY_BITS)
  ) u_eval (
    .meta_i     (meta_rd_i),
    .key_i      (key_rd_i),
    .hash_i     (hash_rd_i),
    .req_key_i  (key_q),
    .req_hash_i (hash_q),
    .eval_o     (eval)
  );

  assign last_slot  = (step_q == LAST);
  assign key_wr_o   = key_q;
  assign hash_wr_o  = hash_q;
  assign value_wr_o = val_in_q;

  // Sequencer: next state, store accesses and result.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    step_d    = step_q;
    occ_d     = occ_q;
    req_d     = req_q;
    key_d     = key_q;
    hash_d    = hash_q;
    val_in_d  = val_in_q;
    done_d    = 1'b0;
    status_d  = status_q;
    vout_d    = vout_q;
    rkey_d    = rkey_q;
    cmd_o     = '0;
    meta_wr_o = '0;
    wr_addr_o = idx_q;
    // The next slot is read ahead while the current one is evaluated.
    rd_addr_o = idx_q + AW'(1);

    case (state_q)
      ST_CLEAR: begin
        // Sweep the metadata to free, zero-count slots.
        cmd_o.meta_we = 1'b1;
        idx_d         = idx_q + AW'(1);
        if (idx_q == LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        rd_addr_o = key_hash_i[AW-1:0];
        if (start) begin
          req_d    = req_type_i;
          key_d    = key_i[KEY_BITS-1:0];
          hash_d   = key_hash_i;
          val_in_d = value_in_i;
          idx_d    = key_hash_i[AW-1:0];
          step_d   = '0;
          vout_d   = '0;
          rkey_d   = '0;
          if (req_type_i == lpm_pkg::REQ_GET || req_type_i == lpm_pkg::REQ_ERASE ||
              (req_type_i == lpm_pkg::REQ_PUT && occ_q != OCC_FULL)) begin
            state_d = ST_PROBE;
          end else if (req_type_i == lpm_pkg::REQ_PUT) begin
            // Put on a full table is answered at once.
            done_d   = 1'b1;
            status_d = lpm_pkg::STATUS_FULL;
          end else begin
            // Unused request type.
            done_d   = 1'b1;
            status_d = lpm_pkg::STATUS_MISS;
          end
        end
      end

      ST_PROBE: begin
        idx_d  = idx_q + AW'(1);
        step_d = step_q + AW'(1);
        case (req_q)
          lpm_pkg::REQ_PUT: begin
            // A free slot is known to exist on the path.
            cmd_o.meta_we = 1'b1;
            if (!meta_rd_i.busy) begin
              cmd_o.data_we   = 1'b1;
              meta_wr_o.busy  = 1'b1;
              meta_wr_o.count = meta_rd_i.count;
              occ_d           = occ_q + OW'(1);
              done_d          = 1'b1;
              status_d        = lpm_pkg::STATUS_OK;
              state_d         = ST_IDLE;
            end else begin
              meta_wr_o.busy  = 1'b1;
              meta_wr_o.count = eval.count_inc;
            end
          end

          lpm_pkg::REQ_ERASE: begin
            cmd_o.meta_we = 1'b1;
            if (eval.hit) begin
              meta_wr_o.busy  = 1'b0;
              meta_wr_o.count = meta_rd_i.count;
              occ_d           = occ_q - OW'(1);
              rkey_d          = lpm_pkg::KEY_W'(key_rd_i);
              done_d          = 1'b1;
              status_d        = lpm_pkg::STATUS_OK;
              state_d         = ST_IDLE;
            end else begin
              meta_wr_o.busy  = meta_rd_i.busy;
              meta_wr_o.count = eval.count_dec;
              if (last_slot) begin
                done_d   = 1'b1;
                status_d = lpm_pkg::STATUS_MISS;
                state_d  = ST_IDLE;
              end
            end
          end

          default: begin
            // Get: a slot outside the chain with a zero count ends the search.
            if (eval.hit) begin
              vout_d   = value_rd_i;
              done_d   = 1'b1;
              status_d = lpm_pkg::STATUS_OK;
              state_d  = ST_IDLE;
            end else if ((!eval.same_hash && eval.count_zero) || last_slot) begin
              done_d   = 1'b1;
              status_d = lpm_pkg::STATUS_MISS;
              state_d  = ST_IDLE;
            end
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      idx_q    <= '0;
      step_q   <= '0;
      occ_q    <= '0;
      req_q    <= '0;
      key_q    <= '0;
      hash_q   <= '0;
      val_in_q <= '0;
      done_q   <= 1'b0;
      status_q <= '0;
      vout_q   <= '0;
      rkey_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      step_q   <= step_d;
      occ_q    <= occ_d;
      req_q    <= req_d;
      key_q    <= key_d;
      hash_q   <= hash_d;
      val_in_q <= val_in_d;
      done_q   <= done_d;
      status_q <= status_d;
      vout_q   <= vout_d;
      rkey_q   <= rkey_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign value_out_o   = $signed(vout_q);
  assign removed_key_o = rkey_q;

endmodule

// ----- rtl/core/linear_probe_map_chain_counts.sv -----
// ----------------------------------------------------------------------------
// linear_probe_map_chain_counts: linear probing hash table with chain counts
// Get, put and erase requests on an open-addressing table whose slots keep
// a count of live entries placed beyond them on their probe path.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start, busy               req_type_i, key_i,
//                                                  key_hash_i, value_in_i
//   result    out        done_o (one-cycle pulse)  status_o, value_out_o,
//                                                  removed_key_o
//
// A request is taken when start is high and busy is low. A request visits
// from 1 up to CAPACITY slots, keeping busy high while it does, and its
// result pulses on done_o as busy falls; the single read port
// of the slot memories sets the pace of one slot per cycle. A put on a full
// table and an unused request type are answered in the next cycle without
// raising busy. After reset busy stays high while the slot metadata is
// cleared. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module linear_probe_map_chain_counts #(
  parameter int unsigned CAPACITY = lpm_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = lpm_pkg::KEY_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lpm_pkg::REQ_W-1:0]            req_type_i,
  input  logic [lpm_pkg::KEY_W-1:0]            key_i,
  input  logic [lpm_pkg::HASH_W-1:0]           key_hash_i,
  input  logic signed [lpm_pkg::VALUE_W-1:0]   value_in_i,
  output logic                                 done_o,
  output logic [lpm_pkg::STATUS_W-1:0]         status_o,
  output logic signed [lpm_pkg::VALUE_W-1:0]   value_out_o,
  output logic [lpm_pkg::KEY_W-1:0]            removed_key_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  lpm_pkg::store_cmd_t           cmd;
  lpm_pkg::meta_t                meta_wr;
  lpm_pkg::meta_t                meta_rd;
  logic [KEY_BITS-1:0]           key_wr;
  logic [KEY_BITS-1:0]           key_rd;
  logic [lpm_pkg::HASH_W-1:0]    hash_wr;
  logic [lpm_pkg::HASH_W-1:0]    hash_rd;
  logic [lpm_pkg::VALUE_W-1:0]   value_wr;
  logic [lpm_pkg::VALUE_W-1:0]   value_rd;

  // Probe sequencer.
  lpm_probe_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .key_hash_i    (key_hash_i),
    .value_in_i    (value_in_i),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .cmd_o         (cmd),
    .meta_wr_o     (meta_wr),
    .key_wr_o      (key_wr),
    .hash_wr_o     (hash_wr),
    .value_wr_o    (value_wr),
    .meta_rd_i     (meta_rd),
    .key_rd_i      (key_rd),
    .hash_rd_i     (hash_rd),
    .value_rd_i    (value_rd),
    .done_o        (done_o),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .removed_key_o (removed_key_o)
  );

  // Slot memories.
  lpm_slot_store #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .cmd_i      (cmd),
    .meta_wr_i  (meta_wr),
    .key_wr_i   (key_wr),
    .hash_wr_i  (hash_wr),
    .value_wr_i (value_wr),
    .meta_rd_o  (meta_rd),
    .key_rd_o   (key_rd),
    .hash_rd_o  (hash_rd),
    .value_rd_o (value_rd)
  );

endmodule
